// ===== rtl/can_sc_pkg.sv =====
// ----------------------------------------------------------------------------
// can_sc_pkg
// Shared types, register indexes and field helpers of the CAN signal codec.
// ----------------------------------------------------------------------------
package can_sc_pkg;

  // request kinds
  localparam logic KIND_DECODE = 1'b0;
  localparam logic KIND_ENCODE = 1'b1;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_BIT  = 3'd0,
    REG_BIT_LENGTH = 3'd1,
    REG_BIG_ENDIAN = 3'd2,
    REG_SIGNED     = 3'd3,
    REG_SCALE      = 3'd4,
    REG_INV_SCALE  = 3'd5,
    REG_OFFSET     = 3'd6
  } reg_idx_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;

  // live configuration, field length already limited to 64
  typedef struct packed {
    logic [5:0]  start_bit;
    logic [6:0]  len;
    logic        big_endian;
    logic        signed_mode;
    logic [31:0] scale;
    logic [31:0] inv_scale;
    logic [47:0] offset;
  } cfg_t;

  // multiplier operands after the front stages
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic        neg;
    logic [64:0] a;
    logic [32:0] b;
  } front_out_t;

  // full product after the multiplier stages
  typedef struct packed {
    logic        valid;
    logic        kind;
    logic        neg;
    logic [97:0] sum;
  } mul_out_t;

  // ones in the low len bits
  function automatic logic [63:0] len_mask(input logic [6:0] len);
    logic [63:0] m;
    if (len[6]) begin
      m = '1;
    end else begin
      m = (64'd1 << len[5:0]) - 64'd1;
    end
    return m;
  endfunction

  // byte reversal of 16, 32 and 64 bit fields, others pass
  function automatic logic [63:0] swap_field(input logic [63:0] w,
                                             input logic [6:0]  len,
                                             input logic        be);
    logic [63:0] r;
    r = w;
    if (be) begin
      unique case (len)
        7'd16: r = {48'd0, w[7:0], w[15:8]};
        7'd32: r = {32'd0, w[7:0], w[15:8], w[23:16], w[31:24]};
        7'd64: r = {w[7:0], w[15:8], w[23:16], w[31:24],
                    w[39:32], w[47:40], w[55:48], w[63:56]};
        default: r = w;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== rtl/can_sc_cfg.sv =====
// ----------------------------------------------------------------------------
// can_sc_cfg
// Configuration register file of the CAN signal codec.
// ----------------------------------------------------------------------------
module can_sc_cfg (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [can_sc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [can_sc_pkg::CFG_DATA_W-1:0]     cfg_data,
  output can_sc_pkg::cfg_t                      cfg
);

  logic [5:0]  start_bit;
  logic [6:0]  bit_length;
  logic        big_endian;
  logic        signed_mode;
  logic [31:0] scale_q16;
  logic [31:0] inv_scale_q16;
  logic [47:0] offset_q16;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes by index, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      start_bit     <= 6'd0;
      bit_length    <= 7'd8;
      big_endian    <= 1'b0;
      signed_mode   <= 1'b0;
      scale_q16     <= 32'd65536;
      inv_scale_q16 <= 32'd65536;
      offset_q16    <= 48'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (can_sc_pkg::reg_idx_t'(cfg_index))
        can_sc_pkg::REG_START_BIT:  start_bit     <= cfg_data[5:0];
        can_sc_pkg::REG_BIT_LENGTH: bit_length    <= cfg_data[6:0];
        can_sc_pkg::REG_BIG_ENDIAN: big_endian    <= cfg_data[0];
        can_sc_pkg::REG_SIGNED:     signed_mode   <= cfg_data[0];
        can_sc_pkg::REG_SCALE:      scale_q16     <= cfg_data[31:0];
        can_sc_pkg::REG_INV_SCALE:  inv_scale_q16 <= cfg_data[31:0];
        can_sc_pkg::REG_OFFSET:     offset_q16    <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // lengths above 64 act as 64
  always_comb begin
    cfg.start_bit   = start_bit;
    cfg.len         = bit_length[6] ? 7'd64 : bit_length;
    cfg.big_endian  = big_endian;
    cfg.signed_mode = signed_mode;
    cfg.scale       = scale_q16;
    cfg.inv_scale   = inv_scale_q16;
    cfg.offset      = offset_q16;
  end

endmodule

// ===== rtl/can_sc_front.sv =====
// ----------------------------------------------------------------------------
// can_sc_front
// Field extraction / offset removal and sign-magnitude operand stages.
// ----------------------------------------------------------------------------
module can_sc_front (
  input  logic                   clk,
  input  logic                   rst,
  input  can_sc_pkg::cfg_t       cfg,
  input  logic                   accept,
  input  logic                   kind,
  input  logic [63:0]            payload,
  input  logic [63:0]            physical_value,
  output can_sc_pkg::front_out_t fo
);

  logic        s1_valid;
  logic        s1_kind;
  logic [64:0] s1_word;

  logic [63:0] field_mask;
  logic [63:0] max_neg;
  logic [63:0] raw;
  logic [63:0] raw_sw;
  logic [64:0] diff;
  logic [64:0] word_next;

  logic        sign_hit;
  logic [64:0] dec_a;
  logic        dneg;
  logic [63:0] mag;
  logic        ineg;
  logic [31:0] imag;

  // stage 1: pick the field or subtract the offset
  always_comb begin
    field_mask = can_sc_pkg::len_mask(cfg.len);
    max_neg    = field_mask ^ (field_mask >> 1);
    raw        = (payload >> cfg.start_bit) & field_mask;
    raw_sw     = can_sc_pkg::swap_field(raw, cfg.len, cfg.big_endian);
    diff       = {physical_value[63], physical_value}
               - {{17{cfg.offset[47]}}, cfg.offset};
    word_next  = (kind == can_sc_pkg::KIND_ENCODE) ? diff : {1'b0, raw_sw};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind <= kind;
    s1_word <= word_next;
  end

  // stage 2: signed raw for decode, magnitudes for encode
  always_comb begin
    sign_hit = cfg.signed_mode & (|(s1_word[63:0] & max_neg));
    dec_a    = sign_hit ? {1'b1, s1_word[63:0] | ~field_mask}
                        : {1'b0, s1_word[63:0]};
    dneg     = s1_word[64];
    mag      = dneg ? (~s1_word[63:0] + 64'd1) : s1_word[63:0];
    ineg     = cfg.inv_scale[31];
    imag     = ineg ? (~cfg.inv_scale + 32'd1) : cfg.inv_scale;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fo.valid <= 1'b0;
    end else begin
      fo.valid <= s1_valid;
    end
    fo.kind <= s1_kind;
    if (s1_kind == can_sc_pkg::KIND_ENCODE) begin
      fo.neg <= dneg ^ ineg;
      fo.a   <= {1'b0, mag};
      fo.b   <= {1'b0, imag};
    end else begin
      fo.neg <= 1'b0;
      fo.a   <= dec_a;
      fo.b   <= {cfg.scale[31], cfg.scale};
    end
  end

endmodule

// ===== rtl/can_sc_mul.sv =====
// ----------------------------------------------------------------------------
// can_sc_mul
// 65 x 33 signed multiply as two 33 x 33 partial products and a final add.
// ----------------------------------------------------------------------------
module can_sc_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  can_sc_pkg::front_out_t fo,
  output can_sc_pkg::mul_out_t   mo
);

  logic signed [32:0] op_lo;
  logic signed [32:0] op_hi;
  logic signed [32:0] op_b;
  logic signed [65:0] prod_lo;
  logic signed [65:0] prod_hi;

  logic               p_valid;
  logic               p_kind;
  logic               p_neg;
  logic [65:0]        p_lo;
  logic [65:0]        p_hi;

  // stage 3: partial products, low half unsigned, high half signed
  always_comb begin
    op_lo   = $signed({1'b0, fo.a[31:0]});
    op_hi   = $signed(fo.a[64:32]);
    op_b    = $signed(fo.b);
    prod_lo = op_lo * op_b;
    prod_hi = op_hi * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= fo.valid;
    end
  end

  always_ff @(posedge clk) begin
    p_kind <= fo.kind;
    p_neg  <= fo.neg;
    p_lo   <= prod_lo;
    p_hi   <= prod_hi;
  end

  // stage 4: combine the partial products
  always_ff @(posedge clk) begin
    if (rst) begin
      mo.valid <= 1'b0;
    end else begin
      mo.valid <= p_valid;
    end
    mo.kind <= p_kind;
    mo.neg  <= p_neg;
    mo.sum  <= {p_hi, 32'd0} + {{32{p_lo[65]}}, p_lo};
  end

endmodule

// ===== rtl/can_sc_back.sv =====
// ----------------------------------------------------------------------------
// can_sc_back
// Offset add / field range clamp, then saturation and payload packing.
// ----------------------------------------------------------------------------
module can_sc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  can_sc_pkg::cfg_t     cfg,
  input  can_sc_pkg::mul_out_t mo,
  output logic                 done,
  output logic [63:0]          decoded_value,
  output logic [63:0]          encoded_payload,
  output logic                 saturated
);

  localparam logic [63:0] MIN64 = {1'b1, 63'd0};
  localparam logic [63:0] MAX64 = {1'b0, {63{1'b1}}};

  logic [63:0] field_mask;
  logic [63:0] max_pos;
  logic [63:0] max_neg;
  logic [97:0] total;
  logic [63:0] q;
  logic        rneg;
  logic [63:0] lim;
  logic [63:0] qc;
  logic        enc_sat;
  logic        enc_neg;

  logic        s5_valid;
  logic        s5_kind;
  logic [97:0] s5_word;
  logic        s5_sat;
  logic        s5_neg;

  logic        fits;
  logic [63:0] dec_res;
  logic [63:0] val;
  logic [63:0] enc_res;

  // stage 5: decode offset add, encode clamp to the field range
  always_comb begin
    field_mask = can_sc_pkg::len_mask(cfg.len);
    max_pos    = field_mask >> 1;
    max_neg    = field_mask ^ max_pos;
    total      = mo.sum + {{50{cfg.offset[47]}}, cfg.offset};
    q          = mo.sum[95:32];
    rneg       = mo.neg & (q != 64'd0);
    enc_neg    = 1'b0;
    if (!cfg.signed_mode) begin
      lim = field_mask;
      if (rneg) begin
        qc      = 64'd0;
        enc_sat = 1'b1;
      end else begin
        enc_sat = q > lim;
        qc      = enc_sat ? lim : q;
      end
    end else begin
      lim     = rneg ? max_neg : max_pos;
      enc_sat = q > lim;
      qc      = enc_sat ? lim : q;
      enc_neg = rneg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= mo.valid;
    end
  end

  always_ff @(posedge clk) begin
    s5_kind <= mo.kind;
    if (mo.kind == can_sc_pkg::KIND_ENCODE) begin
      s5_word <= {34'd0, qc};
      s5_sat  <= enc_sat;
      s5_neg  <= enc_neg;
    end else begin
      s5_word <= total;
      s5_sat  <= 1'b0;
      s5_neg  <= 1'b0;
    end
  end

  // stage 6: decode saturation, encode negate, mask, swap and place
  always_comb begin
    fits    = (&s5_word[97:63]) | ~(|s5_word[97:63]);
    dec_res = fits ? s5_word[63:0] : (s5_word[97] ? MIN64 : MAX64);
    val     = s5_neg ? (~s5_word[63:0] + 64'd1) : s5_word[63:0];
    enc_res = can_sc_pkg::swap_field(val & field_mask, cfg.len, cfg.big_endian)
              << cfg.start_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s5_kind == can_sc_pkg::KIND_ENCODE) begin
      decoded_value   <= 64'd0;
      encoded_payload <= enc_res;
      saturated       <= s5_sat;
    end else begin
      decoded_value   <= dec_res;
      encoded_payload <= 64'd0;
      saturated       <= ~fits;
    end
  end

endmodule

// ===== rtl/can_signal_codec_top.sv =====
// ----------------------------------------------------------------------------
// can_signal_codec_top
// CAN signal decode / encode in Q16.16 fixed point, six-stage pipeline.
// ----------------------------------------------------------------------------
// A request is taken at every clock edge with start high; busy is always low,
// so one request per cycle is sustained. Each request gives one result: done
// is high for exactly one cycle with decoded_value, encoded_payload and
// saturated valid. The receiver cannot stall and must take the result in that
// cycle. The pipeline stages are: field pick, sign/magnitude, two partial
// products of the 65 x 33 multiply, their sum, offset add or clamp, then
// saturation and packing. Configuration writes are always ready and take
// effect at once; write them only while no request is in flight.
module can_signal_codec_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              kind,
  input  logic [63:0]                       payload,
  input  logic [63:0]                       physical_value,
  output logic                              done,
  output logic [63:0]                       decoded_value,
  output logic [63:0]                       encoded_payload,
  output logic                              saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [can_sc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [can_sc_pkg::CFG_DATA_W-1:0] cfg_data
);

  can_sc_pkg::cfg_t       cfg;
  can_sc_pkg::front_out_t fo;
  can_sc_pkg::mul_out_t   mo;
  logic                   accept;

  // fully pipelined, never holds off a request
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  can_sc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  can_sc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .kind           (kind),
    .payload        (payload),
    .physical_value (physical_value),
    .fo             (fo)
  );

  can_sc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .fo  (fo),
    .mo  (mo)
  );

  can_sc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .mo              (mo),
    .done            (done),
    .decoded_value   (decoded_value),
    .encoded_payload (encoded_payload),
    .saturated       (saturated)
  );

endmodule

// ===== tb/sv/can_signal_codec_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_signal_codec_checker
// Watches the request, result and register channels of the CAN signal codec,
// keeps its own copy of the registers, works out the expected conversion of
// every accepted request and compares each result against the oldest one.
// ----------------------------------------------------------------------------
module can_signal_codec_checker
  import can_sc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  logic                  kind,
  input  logic [63:0]           payload,
  input  logic [63:0]           physical_value,
  input  logic                  done,
  input  logic [63:0]           decoded_value,
  input  logic [63:0]           encoded_payload,
  input  logic                  saturated,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding
);

  typedef struct packed {
    logic [63:0] dec;
    logic [63:0] enc;
    logic        sat;
  } conversion_t;

  // register copy, reset values
  logic [5:0]         start_bit_r = 6'd0;
  logic [6:0]         bit_len_r   = 7'd8;
  logic               big_end_r   = 1'b0;
  logic               signed_r    = 1'b0;
  logic signed [31:0] scale_r     = 32'sd65536;
  logic signed [31:0] inv_scale_r = 32'sd65536;
  logic signed [47:0] offset_r    = 48'sd0;

  conversion_t pending_conversions[$];
  int          mismatch_count = 0;

  // ones in the low n bits
  function automatic logic [63:0] field_mask(input int unsigned n);
    return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
  endfunction

  // byte reversal, only for 16, 32 and 64 bit fields
  function automatic logic [63:0] reverse_bytes(input logic [63:0] w,
                                                input int unsigned n,
                                                input logic en);
    logic [63:0] r;
    int unsigned nb;
    r = '0;
    nb = n / 8;
    if (!en || !(n == 16 || n == 32 || n == 64)) return w;
    for (int i = 0; i < nb; i++) r[8*(nb-1-i) +: 8] = w[8*i +: 8];
    return r;
  endfunction

  // conversion of one request under the current register copy
  function automatic conversion_t predicted_conversion(input logic k,
                                                       input logic [63:0] pl,
                                                       input logic signed [63:0] pv);
    conversion_t res;
    int unsigned len;
    logic [63:0] m, fld, q, lim_pos, lim_neg, val;
    logic signed [65:0] rv, diff;
    logic signed [99:0] acc;
    logic signed [32:0] inv_x;
    logic [65:0] dmag;
    logic [32:0] imag;
    logic [97:0] prod;
    logic rneg;
    res = '0;
    len = (bit_len_r > 7'd64) ? 64 : 32'(bit_len_r);
    m = field_mask(len);
    if (k == KIND_DECODE) begin
      fld = reverse_bytes((pl >> start_bit_r) & m, len, big_end_r);
      if (signed_r && len != 0 && fld[len-1]) begin
        rv = $signed({2'b11, fld | ~m});
      end else begin
        rv = $signed({2'b00, fld});
      end
      // exact product plus offset, then clamp to 64 bits
      acc = 100'(rv) * 100'(scale_r) + 100'(offset_r);
      if (acc[99:63] == {37{1'b0}} || acc[99:63] == {37{1'b1}}) begin
        res.dec = acc[63:0];
      end else begin
        res.sat = 1'b1;
        res.dec = acc[99] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
    end else begin
      // sign and magnitude of (value - offset) * inverse scale
      diff = 66'(pv) - 66'(offset_r);
      dmag = diff[65] ? -diff : diff;
      inv_x = 33'(inv_scale_r);
      imag = inv_x[32] ? -inv_x : inv_x;
      prod = 98'(dmag) * 98'(imag);
      q = prod[95:32];
      rneg = (diff[65] != inv_x[32]) && (q != 64'd0);
      if (!signed_r) begin
        if (rneg) begin
          val = '0;
          res.sat = 1'b1;
        end else if (q > m) begin
          val = m;
          res.sat = 1'b1;
        end else begin
          val = q;
        end
      end else begin
        lim_pos = (len == 0) ? 64'd0 : field_mask(len - 1);
        lim_neg = (len == 0) ? 64'd0 : lim_pos + 64'd1;
        if (rneg) begin
          if (q > lim_neg) begin
            q = lim_neg;
            res.sat = 1'b1;
          end
          val = -q;
        end else begin
          if (q > lim_pos) begin
            q = lim_pos;
            res.sat = 1'b1;
          end
          val = q;
        end
      end
      res.enc = reverse_bytes(val & m, len, big_end_r) << start_bit_r;
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // register writes, result compare, request capture
  always @(posedge clk) begin : monitor
    conversion_t want;
    if (rst) begin
      start_bit_r = 6'd0;
      bit_len_r   = 7'd8;
      big_end_r   = 1'b0;
      signed_r    = 1'b0;
      scale_r     = 32'sd65536;
      inv_scale_r = 32'sd65536;
      offset_r    = 48'sd0;
      pending_conversions.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_START_BIT:  start_bit_r = cfg_data[5:0];
          REG_BIT_LENGTH: bit_len_r   = cfg_data[6:0];
          REG_BIG_ENDIAN: big_end_r   = cfg_data[0];
          REG_SIGNED:     signed_r    = cfg_data[0];
          REG_SCALE:      scale_r     = cfg_data[31:0];
          REG_INV_SCALE:  inv_scale_r = cfg_data[31:0];
          REG_OFFSET:     offset_r    = cfg_data[47:0];
          default: ;
        endcase
      end
      if (done) begin
        if (pending_conversions.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no request waiting, expected none, actual %h %h %b",
                   $time, decoded_value, encoded_payload, saturated);
        end else begin
          want = pending_conversions.pop_front();
          compare_field("decoded_value", want.dec, decoded_value);
          compare_field("encoded_payload", want.enc, encoded_payload);
          compare_field("saturated", {63'd0, want.sat}, {63'd0, saturated});
        end
      end
      if (start && !busy) begin
        pending_conversions.push_back(predicted_conversion(kind, payload, physical_value));
      end
    end
    outstanding <= pending_conversions.size();
    errors      <= mismatch_count;
  end

endmodule

// ===== tb/sv/tb_can_signal_codec_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_signal_codec_top
// Drives decode and encode requests and register settings into the CAN signal
// codec: a directed set of corner cases first, then random phases under
// random register settings, with random gaps on both request channels. The
// checker beside the block judges every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_can_signal_codec_top;
  import can_sc_pkg::*;

  localparam int IDLE_PCT        = 24;
  localparam int RAND_PHASES     = 14;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int QUIET_PHASE     = 5;
  localparam int LATENCY_SLACK   = 12;
  localparam int TIMEOUT_CYCLES  = 200000;

  logic                  clk            = 1'b0;
  logic                  rst            = 1'b1;
  logic                  start          = 1'b0;
  logic                  kind           = KIND_DECODE;
  logic [63:0]           payload        = '0;
  logic [63:0]           physical_value = '0;
  logic                  cfg_valid      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = REG_START_BIT;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  busy, done, saturated, cfg_ready;
  logic [63:0]           decoded_value, encoded_payload;
  int                    errors, outstanding;
  int                    idle_pct = IDLE_PCT;
  int                    cycle_count = 0;

  always #5 clk = ~clk;

  can_signal_codec_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .payload(payload), .physical_value(physical_value), .done(done),
    .decoded_value(decoded_value), .encoded_payload(encoded_payload),
    .saturated(saturated), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  can_signal_codec_checker checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .payload(payload), .physical_value(physical_value), .done(done),
    .decoded_value(decoded_value), .encoded_payload(encoded_payload),
    .saturated(saturated), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  // one request, after a random number of idle cycles
  task automatic send_request(input logic k, input logic [63:0] pl, input logic [63:0] pv);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    kind           <= k;
    payload        <= pl;
    physical_value <= pv;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    while ($urandom_range(0, 99) < idle_pct) begin
      cfg_valid <= 1'b0;
      @(posedge clk);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all seven registers, block idle
  task automatic program_codec(input logic [5:0] sb, input logic [6:0] bl, input logic be,
                               input logic sm, input logic [31:0] sc,
                               input logic [31:0] isc, input logic [47:0] off);
    write_reg(REG_START_BIT, {42'd0, sb});
    write_reg(REG_BIT_LENGTH, {41'd0, bl});
    write_reg(REG_BIG_ENDIAN, {47'd0, be});
    write_reg(REG_SIGNED, {47'd0, sm});
    write_reg(REG_SCALE, {16'd0, sc});
    write_reg(REG_INV_SCALE, {16'd0, isc});
    write_reg(REG_OFFSET, off);
    cfg_valid <= 1'b0;
  endtask

  // stop requests and wait for every result
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(0, 4))
      0: return 32'h0001_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endcase
  endfunction

  // run length guard
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= TIMEOUT_CYCLES);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [5:0]  sb;
    logic [6:0]  bl;
    logic        be, sm;
    logic [31:0] sc, isc, r32;
    logic [47:0] off;
    logic [63:0] pl, pv;
    int          small_int;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: unsigned 8-bit field at bit 0, unity scale
    send_request(KIND_DECODE, 64'h0, 64'h0);
    send_request(KIND_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_request(KIND_ENCODE, 64'h0, 64'h0);
    send_request(KIND_ENCODE, 64'h0, 64'h0000_0000_00FF_0000);
    send_request(KIND_ENCODE, 64'h0, 64'h0000_0000_0100_0000);
    send_request(KIND_ENCODE, 64'h0, 64'h8000_0000_0000_0000);
    send_request(KIND_ENCODE, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF);
    drain();

    // field running past bit 63, negative scales, largest offset
    program_codec(6'd60, 7'd16, 1'b1, 1'b1, 32'hFFFF_0000, 32'hFFFF_0000,
                  48'h7FFF_FFFF_FFFF);
    send_request(KIND_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_request(KIND_DECODE, 64'hA5C3_0000_0000_0000, 64'h0);
    send_request(KIND_ENCODE, 64'h0, 64'h0);
    send_request(KIND_ENCODE, 64'h0, 64'h0000_7FFF_FFFA_FFFF);
    drain();

    // full 64-bit swapped field, extreme scales, smallest offset
    program_codec(6'd0, 7'd64, 1'b1, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000,
                  48'h8000_0000_0000);
    send_request(KIND_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_request(KIND_DECODE, 64'h0100_0000_0000_0000, 64'h0);
    send_request(KIND_ENCODE, 64'h0, 64'h0);
    send_request(KIND_ENCODE, 64'h0, 64'h8000_0000_0000_0000);
    drain();

    // empty field
    program_codec(6'd7, 7'd0, 1'b0, 1'b1, 32'h0001_0000, 32'h0001_0000, 48'h0);
    send_request(KIND_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_request(KIND_ENCODE, 64'h0, 64'h0);
    send_request(KIND_ENCODE, 64'h0, 64'h0000_0000_0003_0000);
    send_request(KIND_ENCODE, 64'h0, 64'hFFFF_FFFF_FFFD_0000);
    drain();

    // length above 64 acts as 64, signed decode overflow both ways
    program_codec(6'd0, 7'd127, 1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 48'h0);
    send_request(KIND_DECODE, 64'h0000_0000_0000_0080, 64'h0);
    send_request(KIND_DECODE, 64'h0000_0000_0000_0001, 64'h0);
    send_request(KIND_DECODE, 64'h0, 64'h0);
    send_request(KIND_ENCODE, 64'h0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(KIND_ENCODE, 64'h0, 64'h8000_0000_0000_0000);
    drain();

    // big endian on a 12-bit field leaves bytes alone
    program_codec(6'd5, 7'd12, 1'b1, 1'b1, 32'h0001_8000, 32'h0000_AAAB,
                  48'h0000_0001_8000);
    send_request(KIND_DECODE, 64'hFEDC_BA98_7654_3210, 64'h0);
    send_request(KIND_ENCODE, 64'h0, 64'hFFFF_FFF0_0000_0000);
    send_request(KIND_ENCODE, 64'h0, 64'h0000_0000_0064_0000);
    drain();

    // random phases
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_pct = (ph == QUIET_PHASE) ? 0 : IDLE_PCT;
      case ($urandom_range(0, 3))
        0: sb = 6'd0;
        1: sb = 6'd63;
        default: sb = 6'($urandom_range(0, 63));
      endcase
      case ($urandom_range(0, 11))
        0: bl = 7'd0;
        1: bl = 7'd1;
        2: bl = 7'd16;
        3: bl = 7'd32;
        4: bl = 7'd64;
        5: bl = 7'($urandom_range(65, 127));
        6: bl = 7'd8;
        7: bl = 7'd63;
        default: bl = 7'($urandom_range(1, 64));
      endcase
      be  = 1'($urandom_range(0, 1));
      sm  = 1'($urandom_range(0, 1));
      sc  = rand_scale();
      isc = rand_scale();
      case ($urandom_range(0, 4))
        0: off = 48'h0;
        1: off = 48'h7FFF_FFFF_FFFF;
        2: off = 48'h8000_0000_0000;
        3: off = 48'({$urandom, $urandom});
        default: off = 48'($signed($urandom_range(0, 1 << 20)) - (1 << 19)) << 16;
      endcase
      program_codec(sb, bl, be, sm, sc, isc, off);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        case ($urandom_range(0, 7))
          0: pl = '0;
          1: pl = '1;
          2: pl = 64'd1 << $urandom_range(0, 63);
          default: pl = {$urandom, $urandom};
        endcase
        small_int = $signed($urandom_range(0, 1 << 20)) - (1 << 19);
        r32 = $urandom;
        case ($urandom_range(0, 4))
          0: pv = {$urandom, $urandom};
          1: pv = {{16{r32[31]}}, r32, 16'($urandom)};
          2: pv = (64'(small_int) << 16) | 64'($urandom_range(0, 65535));
          3: pv = {{16{off[47]}}, off} + (64'(small_int % 4096) << 16);
          default: begin
            case ($urandom_range(0, 3))
              0: pv = 64'h8000_0000_0000_0000;
              1: pv = 64'h7FFF_FFFF_FFFF_FFFF;
              2: pv = '0;
              default: pv = '1;
            endcase
          end
        endcase
        send_request($urandom_range(0, 1) ? KIND_ENCODE : KIND_DECODE, pl, pv);
      end
      drain();
    end

    // let any stray result show up
    repeat (LATENCY_SLACK) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
